// ----- src/deq_pkg.sv -----
// deq_pkg: types and constants shared by the double-ended queue modules
// no dependencies

package deq_pkg;

   localparam int DATA_W = 32;

   typedef enum logic [2:0] {
      OP_STATUS     = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_PUSH_BACK  = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_POP_BACK   = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_EMPTY = 2'd1,
      ERR_FULL  = 2'd2
   } error_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FETCH,
      ST_RESP
   } state_type;

   localparam logic signed [DATA_W-1:0] NEG_ONE = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [2:0]               opcode;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] popped_value;
      logic signed [DATA_W-1:0] front_value;
      logic signed [DATA_W-1:0] back_value;
      logic                     is_empty;
      logic [4:0]               fill_count;
      logic [1:0]               error_code;
   } rsp_type;

   // sequencing commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic exec;
      logic fetch;
      logic respond;
   } ctrl_cmd_type;

endpackage

// ----- src/deq_ram.sv -----
// deq_ram: generic ram, one write port and two registered read ports
// no dependencies

module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- src/deq_datapath.sv -----
// deq_datapath: head and count registers, slot ram, result assembly
// depends on deq_pkg and deq_ram

module deq_datapath import deq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  ctrl_cmd_type cmd,
   input  req_type      req_payload,
   output rsp_type      rsp_payload
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW:0]   DEPTH_W = (AW+1)'(DEPTH);
   localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                              input logic [AW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= DEPTH_W) begin
         sum = sum - DEPTH_W;
      end
      return sum[AW-1:0];
   endfunction

   logic [AW-1:0]            head_ff, head_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [2:0]               op_ff;
   logic signed [DATA_W-1:0] value_ff;
   error_type                err_ff, err_in;
   logic                     pop_ok_ff, pop_ok_in;
   logic signed [DATA_W-1:0] popped_ff;

   logic                     full, empty;
   logic [CW-1:0]            cnt_m1;
   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic [AW-1:0]            exec_rd_addr;
   logic [AW-1:0]            rd_addr_a, rd_addr_b;
   logic [DATA_W-1:0]        rd_data_a, rd_data_b;

   assign full   = (count_ff == FULL_C);
   assign empty  = (count_ff == '0);
   assign cnt_m1 = count_ff - 1'b1;

   // one operation: pointer update, slot write, pop address
   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      err_in       = ERR_NONE;
      pop_ok_in    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = head_ff;
      exec_rd_addr = head_ff;
      case (op_ff)
         OP_PUSH_FRONT: begin
            if (full) begin
               err_in = ERR_FULL;
            end else begin
               head_in  = (head_ff == '0) ? LAST : head_ff - 1'b1;
               wr_en    = 1'b1;
               wr_addr  = head_in;
               count_in = count_ff + 1'b1;
            end
         end
         OP_PUSH_BACK: begin
            if (full) begin
               err_in = ERR_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = wrap_add(head_ff, count_ff[AW-1:0]);
               count_in = count_ff + 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               err_in = ERR_EMPTY;
            end else begin
               pop_ok_in    = 1'b1;
               exec_rd_addr = head_ff;
               head_in      = (head_ff == LAST) ? '0 : head_ff + 1'b1;
               count_in     = cnt_m1;
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               err_in = ERR_EMPTY;
            end else begin
               pop_ok_in    = 1'b1;
               exec_rd_addr = wrap_add(head_ff, cnt_m1[AW-1:0]);
               count_in     = cnt_m1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.exec) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_payload.opcode;
         value_ff <= req_payload.value;
      end
      if (cmd.exec) begin
         err_ff    <= err_in;
         pop_ok_ff <= pop_ok_in;
      end
      if (cmd.fetch) begin
         popped_ff <= pop_ok_ff ? $signed(rd_data_a) : NEG_ONE;
      end
   end

   // port a reads the popped slot during exec, then the front slot
   assign rd_addr_a = cmd.exec ? exec_rd_addr : head_ff;
   assign rd_addr_b = wrap_add(head_ff, cnt_m1[AW-1:0]);

   deq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock     (clock),
      .wr_en     (wr_en && cmd.exec),
      .wr_addr   (wr_addr),
      .wr_data   (value_ff),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   always_comb begin
      rsp_payload.popped_value = popped_ff;
      rsp_payload.front_value  = empty ? NEG_ONE : $signed(rd_data_a);
      rsp_payload.back_value   = empty ? NEG_ONE : $signed(rd_data_b);
      rsp_payload.is_empty     = empty;
      rsp_payload.fill_count   = 5'(count_ff);
      rsp_payload.error_code   = err_ff;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_C)
      else $error("element count beyond depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + 1'b1)
               || (count_ff == $past(count_ff) - 1'b1))
      else $error("element count moved by more than one");

endmodule

// ----- src/deq_controller.sv -----
// deq_controller: sequencer for one queue operation
// depends on deq_pkg

module deq_controller import deq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output ctrl_cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      busy        = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- src/double_ended_queue.sv -----
// double_ended_queue: deque of signed 32-bit values in a ring of DEPTH slots
// sequencing: the accepting edge is followed by the exec, fetch and resp states,
//   the result strobe in resp; a new transaction waits for idle, set by the registered
//   slot ram read (one pass for the popped slot, one for the new front and back slots)
// reset: head and count cleared, slots left as they are (never read unwritten)
// the result is shown for one cycle and cannot be stalled by the receiver

module double_ended_queue import deq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_valid,
   output rsp_type rsp_payload
);

   ctrl_cmd_type cmd;

   // sequencer: idle -> exec -> fetch -> resp
   deq_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // pointers, count, slot ram and result fields
   deq_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

   // result strobe is the resp state of the sequencer
   assign rsp_valid = cmd.respond;

   // every accepted transaction yields its result strobe after the exec and fetch states
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("missing result strobe");

   // a result strobe only comes while an operation is in flight
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   // the block is free again right after a result
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("still busy after result");

   // error results leave the fill count where it was
   a_err_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.error_code != ERR_NONE)
      |-> rsp_payload.fill_count == $past(rsp_payload.fill_count, 3))
      else $error("failed operation changed the count");

endmodule

// ----- sim/tb_top.sv -----
// tb_top: self-checking testbench for the double_ended_queue ring-buffer deque
// depends on deq_pkg (transaction types, opcodes, error codes) and the dut rtl
// a directed opener plus random fill and drain bursts, checked by a local predictor

module tb_top import deq_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH         = 16;
   localparam int RANDOM_ITEMS  = 1400;
   localparam int MAX_IDLE      = 6;
   localparam int SETTLE_CYCLES = 16;  // margin after the last result, beyond the result latency
   localparam int REPORT_LIMIT  = 10;
   // opcodes above the last defined one behave as status
   localparam int OP_LAST_CODE  = 2 ** $bits(opcode_type) - 1;

   localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;

   // one pending command for the driver
   typedef struct {
      req_type cmd;
      int      idle_before;  // cycles with start low ahead of this command
      bit      drain_first;  // hold back until every result is back
   } deq_item_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_payload = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_payload;

   deq_item_type pending_items[$];
   rsp_type      expected_results[$];

   // both counters move by nonblocking updates, so any reader at the clock
   // edge sees the values from before that edge
   int sent_count = 0;
   int rsp_count  = 0;
   int mismatch_count = 0;
   int idle_left = -1;  // driver private: -1 means the head item's wait is not loaded

   // predictor state: ring of slots, head pointer and fill level
   logic signed [DATA_W-1:0] ring [DEPTH];
   int ring_head  = 0;
   int ring_count = 0;

   double_ended_queue #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload)
   );

   always #4 clock = ~clock;

   // apply one command to the predicted deque and return the result it must give
   function automatic rsp_type deque_apply(req_type op);
      rsp_type res;
      int      tail;
      res = '0;
      res.popped_value = NEG_ONE;
      res.error_code = ERR_NONE;
      case (op.opcode)
         OP_PUSH_FRONT: begin
            if (ring_count >= DEPTH) begin
               res.error_code = ERR_FULL;
            end else begin
               ring_head = (ring_head + DEPTH - 1) % DEPTH;
               ring[ring_head] = op.value;
               ring_count++;
            end
         end
         OP_PUSH_BACK: begin
            if (ring_count >= DEPTH) begin
               res.error_code = ERR_FULL;
            end else begin
               ring[(ring_head + ring_count) % DEPTH] = op.value;
               ring_count++;
            end
         end
         OP_POP_FRONT: begin
            if (ring_count == 0) begin
               res.error_code = ERR_EMPTY;
            end else begin
               res.popped_value = ring[ring_head];
               ring_head = (ring_head + 1) % DEPTH;
               ring_count--;
            end
         end
         OP_POP_BACK: begin
            if (ring_count == 0) begin
               res.error_code = ERR_EMPTY;
            end else begin
               res.popped_value = ring[(ring_head + ring_count - 1) % DEPTH];
               ring_count--;
            end
         end
         default: ;  // status and the spare codes leave the deque alone
      endcase
      tail = (ring_head + ring_count + DEPTH - 1) % DEPTH;
      res.front_value = (ring_count != 0) ? ring[ring_head] : NEG_ONE;
      res.back_value  = (ring_count != 0) ? ring[tail] : NEG_ONE;
      res.is_empty    = (ring_count == 0);
      res.fill_count  = ring_count[4:0];
      return res;
   endfunction

   task automatic note_mismatch(string field, logic signed [DATA_W-1:0] want,
                                logic signed [DATA_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: %s mismatch: expected %0d (%h), got %0d (%h)",
                  $realtime, field, want, want, got, got);
   endtask

   // pick a value, leaning toward the extremes and the -1 that marks "none"
   function automatic logic signed [DATA_W-1:0] draw_value();
      case ($urandom_range(0, 9))
         0:       return VALUE_MAX;
         1:       return VALUE_MIN;
         2:       return NEG_ONE;
         3:       return '0;
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_op(logic [2:0] code, logic signed [DATA_W-1:0] value,
                           int idle, bit drain);
      deq_item_type item;
      item.cmd.opcode  = code;
      item.cmd.value   = value;
      item.idle_before = idle;
      item.drain_first = drain;
      pending_items.insert(pending_items.size(), item);
   endtask

   // driver: start stays up until the dut takes the transaction, then the next
   // command follows after its own idle count
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && !busy) && start) begin
         // still waiting for the dut to take the current transaction
      end else begin
         if (start)
            sent_count <= sent_count + 1;
         if (pending_items.size() == 0) begin
            start <= 1'b0;
         end else begin
            if (idle_left < 0)
               idle_left = pending_items[0].idle_before;
            if (idle_left > 0) begin
               idle_left--;
               start <= 1'b0;
            end else if (pending_items[0].drain_first &&
                         (sent_count + start != rsp_count)) begin
               start <= 1'b0;  // let every outstanding result come back first
            end else begin
               req_payload <= pending_items[0].cmd;
               pending_items.delete(0);
               start <= 1'b1;
               idle_left = -1;
            end
         end
      end
   end

   // monitor: check the result strobed at this edge against the oldest
   // prediction, then predict for a transaction the dut takes at this edge
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            rsp_count <= rsp_count + 1;
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: unexpected result %p", $realtime, rsp_payload);
            end else begin
               want = expected_results.pop_front();
               if (rsp_payload.popped_value !== want.popped_value)
                  note_mismatch("popped_value", want.popped_value, rsp_payload.popped_value);
               if (rsp_payload.front_value !== want.front_value)
                  note_mismatch("front_value", want.front_value, rsp_payload.front_value);
               if (rsp_payload.back_value !== want.back_value)
                  note_mismatch("back_value", want.back_value, rsp_payload.back_value);
               if (rsp_payload.is_empty !== want.is_empty)
                  note_mismatch("is_empty", DATA_W'(want.is_empty),
                                DATA_W'(rsp_payload.is_empty));
               if (rsp_payload.fill_count !== want.fill_count)
                  note_mismatch("fill_count", DATA_W'(want.fill_count),
                                DATA_W'(rsp_payload.fill_count));
               if (rsp_payload.error_code !== want.error_code)
                  note_mismatch("error_code", DATA_W'(want.error_code),
                                DATA_W'(rsp_payload.error_code));
            end
         end
         if (start && !busy)
            expected_results.insert(expected_results.size(), deque_apply(req_payload));
      end
   end

   // hard stop in case the dut hangs
   initial begin
      #2_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

   // stimulus, reset and end of run
   initial begin
      int random_queued;
      int seg_len;
      int push_pct;
      bit seg_idle;
      int pick;
      logic [2:0] code;

      // directed opener: empty-queue errors first
      queue_op(OP_STATUS, draw_value(), 0, 1'b0);
      queue_op(OP_POP_FRONT, draw_value(), 0, 1'b0);
      queue_op(OP_POP_BACK, draw_value(), 1, 1'b0);
      // extremes at both ends; push front from head zero wraps the ring
      queue_op(OP_PUSH_FRONT, VALUE_MAX, 0, 1'b0);
      queue_op(OP_PUSH_BACK, VALUE_MIN, 0, 1'b0);
      // fill to the top alternating ends, including a stored -1 and zero
      for (int i = 0; i < DEPTH - 2; i++)
         queue_op((i % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT,
                  (i == 0) ? NEG_ONE : (i == 1) ? '0 : $urandom, i % 3, 1'b0);
      // pushes on a full queue must be refused at either end
      queue_op(OP_PUSH_FRONT, draw_value(), 0, 1'b0);
      queue_op(OP_PUSH_BACK, draw_value(), 0, 1'b0);
      // spare opcodes act as status
      for (int c = OP_POP_BACK + 1; c <= OP_LAST_CODE; c++)
         queue_op(c[2:0], draw_value(), 0, 1'b0);
      queue_op(OP_POP_BACK, draw_value(), 0, 1'b0);
      queue_op(OP_POP_FRONT, draw_value(), 2, 1'b0);

      // random part: bursts that lean toward filling, draining or neither,
      // so the deque hits full and empty again and again
      random_queued = 0;
      while (random_queued < RANDOM_ITEMS) begin
         seg_len = $urandom_range(8, 60);
         case ($urandom_range(0, 2))
            0:       push_pct = 80;
            1:       push_pct = 20;
            default: push_pct = 50;
         endcase
         seg_idle = ($urandom_range(0, 2) != 0);
         for (int i = 0; i < seg_len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
               code = 3'($urandom_range(OP_POP_BACK + 1, OP_LAST_CODE));
            else if (pick < 7)
               code = OP_STATUS;
            else if ($urandom_range(0, 99) < push_pct)
               code = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            else
               code = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
            queue_op(code, draw_value(), seg_idle ? $urandom_range(0, MAX_IDLE) : 0,
                     (i == 0) && (random_queued == 0 || $urandom_range(0, 3) == 0));
            random_queued++;
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // wait until all transactions are taken and answered
      do
         @(negedge clock);
      while (pending_items.size() != 0 || start || sent_count != rsp_count);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);

      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
src/deq_pkg.sv
src/deq_ram.sv
src/deq_datapath.sv
src/deq_controller.sv
src/double_ended_queue.sv
sim/tb_top.sv
